// ===== sv/f2h_pkg.sv =====
// Package: constants for the fp32 to fp16/bf16 converter.
`timescale 1ns / 1ps
package f2h_pkg;
    localparam logic [31:0] F32_INF        = 32'h7F80_0000;
    localparam logic [31:0] F16_INF_SCALED = 32'h0F80_0000;
    localparam logic [31:0] CLEAR_LOW12    = 32'hFFFF_F000;
    localparam logic [31:0] ROUND_ADD      = 32'h0000_1000;
    localparam logic [31:0] BIAS_SHIFTED   = 32'h3800_0000;
    localparam logic [15:0] HALF_NAN       = 16'h7FFF;
    localparam logic [15:0] HALF_INF       = 16'h7C00;
    localparam logic [7:0]  EXP_NORMAL_MIN = 8'd113;
    localparam logic [7:0]  SHIFT_BASE     = 8'd113;
    localparam logic        FMT_FP16       = 1'b0;
    localparam logic        FMT_BF16       = 1'b1;
endpackage

// ===== sv/fp32_to_half_converter_core.sv =====
// Top level: fp32 to fp16 / bf16 converter, one item per cycle unless the output stalls.
`timescale 1ns / 1ps
// One binary32 item in, one 16-bit item out. Input register feeds a single
// combinational pass into an output register; the result is registered in the
// output register once it is free, and a stalled output holds the item in the
// input register. Throughput is one item per clock, bounded only by the
// output register handshake. The format register (written through i_cfg_we /
// i_cfg_wdata) = 0 converts to fp16 (NaN -> 0x7FFF, inf -> 0x7C00, subnormal
// results rounded to nearest even at the binary32 denormal LSB, then round half
// up and saturation); 1 passes the top 16 bits through. Write the format only
// while the block is idle.
module fp32_to_half_converter_core
    import f2h_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_single_bits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_half_bits
);
    logic        r_fmt;
    logic        r_in_vld;
    logic [31:0] r_in;
    logic        r_out_vld;
    logic [15:0] r_out;

    logic        s_adv;
    logic        in_ready;
    logic [15:0] n_out;

    // output stage takes data when empty or draining
    assign s_adv    = !r_out_vld || i_ready;
    assign in_ready = !r_in_vld || s_adv;
    assign o_ready  = in_ready;
    assign o_valid  = r_out_vld;
    assign o_half_bits = r_out;

    // fp16 datapath
    logic [31:0] mag, mc, v, va, scaled;
    logic [7:0]  expo, sh;
    logic [23:0] sig, kept, rest, half;
    logic [24:0] kr;
    always_comb begin
        mag  = {1'b0, r_in[30:0]};
        mc   = mag & CLEAR_LOW12;
        expo = mc[30:23];
        sig  = {1'b1, mc[22:0]};
        sh   = SHIFT_BASE - expo;
        kept = '0;
        rest = '0;
        half = '0;
        kr   = '0;
        if (expo >= EXP_NORMAL_MIN) begin
            scaled = mc - BIAS_SHIFTED;
        end else if (expo == 8'd0 || sh >= 8'd25) begin
            scaled = '0; // too small even for half the denormal LSB
        end else begin
            kept = sig >> sh[4:0];
            rest = sig & ((24'd1 << sh[4:0]) - 24'd1);
            half = 24'd1 << (sh[4:0] - 5'd1);
            kr   = {1'b0, kept};
            if (rest > half || (rest == half && kept[0]))
                kr = kr + 25'd1;
            scaled = {7'd0, kr};
        end
        va = scaled + ROUND_ADD;
        v  = (va > F16_INF_SCALED) ? F16_INF_SCALED : va;
        if (r_fmt == FMT_BF16)
            n_out = r_in[31:16];
        else if (mag > F32_INF)
            n_out = HALF_NAN | {r_in[31], 15'd0};
        else if (mag == F32_INF)
            n_out = HALF_INF | {r_in[31], 15'd0};
        else
            n_out = v[28:13] | {r_in[31], 15'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt     <= FMT_FP16;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we)
                r_fmt <= i_cfg_wdata;
            if (in_ready)
                r_in_vld <= i_valid;
            if (s_adv)
                r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_valid)
            r_in <= i_single_bits;
        if (s_adv && r_in_vld)
            r_out <= n_out;
    end
endmodule
